// ===== rtl/random_walk_radial_histogram_macros.svh =====
// assertion macros shared by the random walk histogram design
`ifndef RANDOM_WALK_RADIAL_HISTOGRAM_MACROS_SVH
`define RANDOM_WALK_RADIAL_HISTOGRAM_MACROS_SVH

// same-cycle implication, disabled while in reset
`define RWRH_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rwrh assertion failed");

// next-cycle implication, disabled while in reset
`define RWRH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rwrh assertion failed");

`endif

// ===== rtl/rwrh_pkg.sv =====
// shared types, constants and helpers for the random walk histogram
`timescale 1ns / 1ps

package rwrh_pkg;

    localparam int POS_W  = 6;
    localparam int HE_W   = 4;
    localparam int STEP_W = 4;
    localparam int DIR_W  = 3;
    localparam int RAD_W  = 6;
    localparam int CNT_W  = 32;
    localparam int FRAC_W = 17;
    localparam int D2_W   = 12;
    localparam int QBITS  = 16;

    typedef logic signed [POS_W-1:0] pos_t;
    typedef logic [HE_W-1:0]         half_t;
    typedef logic [DIR_W-1:0]        dir_t;

    // step directions
    localparam dir_t DIR_XP = 3'd0;
    localparam dir_t DIR_XM = 3'd1;
    localparam dir_t DIR_YP = 3'd2;
    localparam dir_t DIR_YM = 3'd3;
    localparam dir_t DIR_ZP = 3'd4;
    localparam dir_t DIR_ZM = 3'd5;

    // item kinds
    localparam logic FUNC_STEP  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

    typedef struct packed {
        logic clr_en;
        logic walk;
        logic scan_start;
        logic scan_run;
        logic div_start;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic walk_final;
        logic hist_done;
        logic scan_last;
        logic acc_done;
        logic div_done;
        logic out_full;
    } ctrl_sts_t;

    function automatic logic [D2_W-1:0] sq(input pos_t v);
        logic [POS_W-1:0] a;
        logic [D2_W-1:0]  ae;
        begin
            a  = v[POS_W-1] ? POS_W'(-v) : POS_W'(v);
            ae = {{(D2_W-POS_W){1'b0}}, a};
            return ae * ae;
        end
    endfunction

endpackage

// ===== rtl/rwrh_req_if.sv =====
// request channel: walk steps and radial queries
`timescale 1ns / 1ps

interface rwrh_req_if
    import rwrh_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              func;
    dir_t              direction;
    logic [RAD_W-1:0]  radius;

    modport source (output valid, func, direction, radius, input ready);
    modport sink   (input valid, func, direction, radius, output ready);
endinterface

// ===== rtl/rwrh_rsp_if.sv =====
// response channel: query results
`timescale 1ns / 1ps

interface rwrh_rsp_if
    import rwrh_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CNT_W-1:0]  inside_count;
    logic [CNT_W-1:0]  total_count;
    logic [FRAC_W-1:0] fraction_q16;
    logic              empty_res;

    modport source (output valid, inside_count, total_count, fraction_q16, empty_res,
                    input ready);
    modport sink   (input valid, inside_count, total_count, fraction_q16, empty_res,
                    output ready);
endinterface

// ===== rtl/rwrh_cfg_if.sv =====
// configuration write channel for the half extent register
`timescale 1ns / 1ps

interface rwrh_cfg_if
    import rwrh_pkg::*;
();
    logic  valid;
    logic  ready;
    half_t half_extent;

    modport source (output valid, half_extent, input ready);
    modport sink   (input valid, half_extent, output ready);
endinterface

// ===== rtl/rwrh_div.sv =====
// serial restoring divider producing a q1.16 ratio
`timescale 1ns / 1ps

module rwrh_div
    import rwrh_pkg::*;
#(
    parameter int NUM_W = 47
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [NUM_W-1:0]  den,
    output logic              done,
    output logic [FRAC_W-1:0] quot
);

    localparam int CW = $clog2(QBITS + 1);

    logic [NUM_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  den_reg;
    logic [FRAC_W-1:0] q_reg;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [NUM_W:0]    shifted;
    logic [NUM_W:0]    diff;
    logic              take;

    // remainder stays below the divisor, so one extra bit holds the shift
    assign shifted = {rem_reg, 1'b0};
    assign diff    = shifted - {1'b0, den_reg};
    assign take    = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start) begin
            if (num >= den) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
            end
            cnt_reg <= CW'(QBITS);
        end
        else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            den_reg <= den;
            rem_reg <= num;
            q_reg   <= (num >= den) ? FRAC_ONE : '0;
        end
        else if (busy_reg) begin
            rem_reg <= take ? diff[NUM_W-1:0] : shifted[NUM_W-1:0];
            q_reg   <= {q_reg[FRAC_W-2:0], take};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// ===== rtl/rwrh_dp.sv =====
// datapath: walker, cell index pipeline, histogram memory, accumulators, result register
`timescale 1ns / 1ps

module rwrh_dp
    import rwrh_pkg::*;
#(
    parameter int MAX_HALF = 15
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ctrl_cmd_t         cmd,
    output ctrl_sts_t         sts,
    input  half_t             n,
    input  dir_t              direction,
    input  logic [RAD_W-1:0]  radius,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CNT_W-1:0]  inside_count,
    output logic [CNT_W-1:0]  total_count,
    output logic [FRAC_W-1:0] fraction_q16,
    output logic              empty_res
);

    localparam int SIDE  = 2 * MAX_HALF + 1;
    localparam int CELLS = SIDE * SIDE * SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int IDX_W = AW + 6;
    localparam int ACC_W = CNT_W + AW;

    function automatic logic [CNT_W-1:0] sat32(input logic [ACC_W-1:0] v);
        begin
            return (|v[ACC_W-1:CNT_W]) ? {CNT_W{1'b1}} : v[CNT_W-1:0];
        end
    endfunction

    // ---------------- walker
    pos_t              px_reg, py_reg, pz_reg;
    pos_t              px_step, py_step, pz_step;
    logic [STEP_W-1:0] steps_reg;
    logic [STEP_W:0]   steps_inc;
    logic              dir_ok;
    logic              walk_final;
    logic              hist_inj;

    assign steps_inc  = {1'b0, steps_reg} + 1'b1;
    assign dir_ok     = direction <= DIR_ZM;
    assign walk_final = dir_ok && (steps_inc >= {1'b0, n});
    assign hist_inj   = cmd.walk && walk_final;

    always_comb begin
        px_step = px_reg;
        py_step = py_reg;
        pz_step = pz_reg;
        case (direction)
            DIR_XP:  px_step = px_reg + 6'sd1;
            DIR_XM:  px_step = px_reg - 6'sd1;
            DIR_YP:  py_step = py_reg + 6'sd1;
            DIR_YM:  py_step = py_reg - 6'sd1;
            DIR_ZP:  pz_step = pz_reg + 6'sd1;
            DIR_ZM:  pz_step = pz_reg - 6'sd1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            px_reg    <= '0;
            py_reg    <= '0;
            pz_reg    <= '0;
            steps_reg <= '0;
        end
        else if (cmd.walk && dir_ok) begin
            if (walk_final) begin
                px_reg    <= '0;
                py_reg    <= '0;
                pz_reg    <= '0;
                steps_reg <= '0;
            end
            else begin
                px_reg    <= px_step;
                py_reg    <= py_step;
                pz_reg    <= pz_step;
                steps_reg <= steps_inc[STEP_W-1:0];
            end
        end
    end

    // ---------------- scan counters
    pos_t             sx_reg, sy_reg, sz_reg;
    pos_t             n_pos, neg_n;
    logic [D2_W-1:0]  r2_reg;
    logic [D2_W-1:0]  rad_e;
    logic             scan_last;

    assign n_pos     = {{(POS_W-HE_W){1'b0}}, n};
    assign neg_n     = -n_pos;
    assign scan_last = (sx_reg == n_pos) && (sy_reg == n_pos) && (sz_reg == n_pos);
    assign rad_e     = {{(D2_W-RAD_W){1'b0}}, radius};

    always_ff @(posedge clk) begin
        if (cmd.scan_start) begin
            sx_reg <= neg_n;
            sy_reg <= neg_n;
            sz_reg <= neg_n;
            r2_reg <= rad_e * rad_e;
        end
        else if (cmd.scan_run) begin
            if (sz_reg != n_pos) begin
                sz_reg <= sz_reg + 6'sd1;
            end
            else begin
                sz_reg <= neg_n;
                if (sy_reg != n_pos) begin
                    sy_reg <= sy_reg + 6'sd1;
                end
                else begin
                    sy_reg <= neg_n;
                    sx_reg <= sx_reg + 6'sd1;
                end
            end
        end
    end

    // ---------------- stage 1: row offset and squared distance
    pos_t                    src_x, src_y, src_z;
    logic signed [IDX_W-1:0] xo, yo, zo, row_next;
    logic                    s1_v_reg, s1_hist_reg, s1_last_reg;
    logic signed [IDX_W-1:0] s1_row_reg, s1_zo_reg;
    logic [D2_W-1:0]         s1_d2_reg;

    assign src_x = hist_inj ? px_step : sx_reg;
    assign src_y = hist_inj ? py_step : sy_reg;
    assign src_z = hist_inj ? pz_step : sz_reg;

    assign xo = {{(IDX_W-POS_W){src_x[POS_W-1]}}, src_x} + IDX_W'(MAX_HALF);
    assign yo = {{(IDX_W-POS_W){src_y[POS_W-1]}}, src_y} + IDX_W'(MAX_HALF);
    assign zo = {{(IDX_W-POS_W){src_z[POS_W-1]}}, src_z} + IDX_W'(MAX_HALF);
    assign row_next = xo * IDX_W'(SIDE) + yo;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_v_reg <= 1'b0;
        end
        else begin
            s1_v_reg <= hist_inj || cmd.scan_run;
        end
    end

    always_ff @(posedge clk) begin
        s1_hist_reg <= hist_inj;
        s1_last_reg <= scan_last;
        s1_row_reg  <= row_next;
        s1_zo_reg   <= zo;
        s1_d2_reg   <= sq(src_x) + sq(src_y) + sq(src_z);
    end

    // ---------------- stage 2: linear address, radius compare
    logic                    s2_v_reg, s2_hist_reg, s2_last_reg, s2_inside_reg;
    logic signed [IDX_W-1:0] s2_idx_reg;
    logic                    s2_ok;

    assign s2_ok = !s2_idx_reg[IDX_W-1] && (s2_idx_reg < IDX_W'(CELLS));

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s2_v_reg <= 1'b0;
        end
        else begin
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk) begin
        s2_hist_reg   <= s1_hist_reg;
        s2_last_reg   <= s1_last_reg;
        s2_idx_reg    <= s1_row_reg * IDX_W'(SIDE) + s1_zo_reg;
        s2_inside_reg <= s1_d2_reg <= r2_reg;
    end

    // ---------------- stage 3: histogram read
    logic [CNT_W-1:0] mem [CELLS];
    logic [CNT_W-1:0] rdata_reg;
    logic             s3_v_reg, s3_hist_reg, s3_last_reg, s3_inside_reg, s3_ok_reg;
    logic [AW-1:0]    s3_addr_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s3_v_reg <= 1'b0;
        end
        else begin
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (s2_v_reg && s2_ok) begin
            rdata_reg <= mem[s2_idx_reg[AW-1:0]];
        end
        s3_hist_reg   <= s2_hist_reg;
        s3_last_reg   <= s2_last_reg;
        s3_inside_reg <= s2_inside_reg;
        s3_ok_reg     <= s2_ok;
        s3_addr_reg   <= s2_idx_reg[AW-1:0];
    end

    // ---------------- histogram write port: clearing pass or saturating increment
    logic [AW-1:0] clr_cnt_reg;
    logic          hist_wr;

    assign hist_wr = s3_v_reg && s3_hist_reg && s3_ok_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_en) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.clr_en) begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (hist_wr) begin
            mem[s3_addr_reg] <= (&rdata_reg) ? rdata_reg : rdata_reg + 1'b1;
        end
    end

    // ---------------- accumulators
    logic [ACC_W-1:0] acc_total_reg, acc_inside_reg, rdata_e;
    logic             acc_en;

    assign rdata_e = {{(ACC_W-CNT_W){1'b0}}, rdata_reg};
    assign acc_en  = s3_v_reg && !s3_hist_reg;

    always_ff @(posedge clk) begin
        if (cmd.scan_start) begin
            acc_total_reg  <= '0;
            acc_inside_reg <= '0;
        end
        else if (acc_en) begin
            acc_total_reg <= acc_total_reg + rdata_e;
            if (s3_inside_reg) begin
                acc_inside_reg <= acc_inside_reg + rdata_e;
            end
        end
    end

    // ---------------- ratio
    logic              div_done;
    logic [FRAC_W-1:0] div_quot;

    rwrh_div #(
        .NUM_W (ACC_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (acc_inside_reg),
        .den   (acc_total_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // ---------------- result register
    logic              out_valid_reg;
    logic [CNT_W-1:0]  inside_reg, total_reg;
    logic [FRAC_W-1:0] frac_reg;
    logic              empty_reg;
    logic              acc_zero;

    assign acc_zero = acc_total_reg == '0;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.out_load) begin
            empty_reg  <= acc_zero;
            inside_reg <= acc_zero ? '0 : sat32(acc_inside_reg);
            total_reg  <= acc_zero ? '0 : sat32(acc_total_reg);
            frac_reg   <= acc_zero ? '0 : div_quot;
        end
    end

    assign out_valid    = out_valid_reg;
    assign inside_count = inside_reg;
    assign total_count  = total_reg;
    assign fraction_q16 = frac_reg;
    assign empty_res    = empty_reg;

    // ---------------- status
    assign sts.clr_last   = clr_cnt_reg == AW'(CELLS - 1);
    assign sts.walk_final = walk_final;
    assign sts.hist_done  = s3_v_reg && s3_hist_reg;
    assign sts.scan_last  = scan_last;
    assign sts.acc_done   = acc_en && s3_last_reg;
    assign sts.div_done   = div_done;
    assign sts.out_full   = out_valid_reg && !out_ready;

endmodule

// ===== rtl/rwrh_ctrl.sv =====
// controller state machine sequencing clear, walk, scan and divide
`timescale 1ns / 1ps

module rwrh_ctrl
    import rwrh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_func,
    output logic      req_ready,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t cmd
);

    typedef enum logic [7:0] {
        S_CLEAR   = 8'b0000_0001,
        S_IDLE    = 8'b0000_0010,
        S_HIST    = 8'b0000_0100,
        S_SCAN    = 8'b0000_1000,
        S_DRAIN   = 8'b0001_0000,
        S_DIVGO   = 8'b0010_0000,
        S_DIVWAIT = 8'b0100_0000,
        S_OUT     = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign req_ready = state_reg == S_IDLE;
    assign accept    = req_valid && req_ready;

    always_comb begin
        cmd            = '0;
        cmd.clr_en     = state_reg == S_CLEAR;
        cmd.walk       = accept && (req_func == FUNC_STEP);
        cmd.scan_start = accept && (req_func == FUNC_QUERY);
        cmd.scan_run   = state_reg == S_SCAN;
        cmd.div_start  = state_reg == S_DIVGO;
        cmd.out_load   = (state_reg == S_OUT) && !sts.out_full;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (req_func == FUNC_QUERY) begin
                        state_next = S_SCAN;
                    end
                    else if (sts.walk_final) begin
                        state_next = S_HIST;
                    end
                end
            end
            S_HIST: begin
                if (sts.hist_done) begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN: begin
                if (sts.scan_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (sts.acc_done) begin
                    state_next = S_DIVGO;
                end
            end
            S_DIVGO: begin
                state_next = S_DIVWAIT;
            end
            S_DIVWAIT: begin
                if (sts.div_done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!sts.out_full) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_CLEAR;
        end
        else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/random_walk_radial_histogram.sv =====
// top level of the 3d lattice random walk with radial density histogram
// walk step: the step that ends a particle closes the request side while the index
//   pipeline reads and bumps the histogram cell
// query: a scan of all (2n+1)^3 cells, one memory read per cycle, then pipeline
//   drain, 16-step serial division and result load
// reset: a clearing pass zeroes the (2*MAX_HALF+1)^3 histogram cells, one per cycle,
//   before the first item is taken; configuration writes are taken throughout
`timescale 1ns / 1ps
`include "random_walk_radial_histogram_macros.svh"

module random_walk_radial_histogram
    import rwrh_pkg::*;
#(
    parameter int MAX_HALF = 15
) (
    input  logic       clk,
    input  logic       rst_n,
    rwrh_req_if.sink   req,
    rwrh_rsp_if.source rsp,
    rwrh_cfg_if.sink   cfg
);

    // half extent register, always writable
    half_t he_reg;
    half_t n_eff;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            he_reg <= HE_W'(1);
        end
        else if (cfg.valid && cfg.ready) begin
            he_reg <= cfg.half_extent;
        end
    end

    // zero runs as one, anything past the lattice bound runs at the bound
    always_comb begin
        if (he_reg == '0) begin
            n_eff = HE_W'(1);
        end
        else if (int'(he_reg) > MAX_HALF) begin
            n_eff = HE_W'(MAX_HALF);
        end
        else begin
            n_eff = he_reg;
        end
    end

    // controller and datapath talk only through these two groups
    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    rwrh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_func  (req.func),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    rwrh_dp #(
        .MAX_HALF (MAX_HALF)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .n            (n_eff),
        .direction    (req.direction),
        .radius       (req.radius),
        .out_valid    (rsp.valid),
        .out_ready    (rsp.ready),
        .inside_count (rsp.inside_count),
        .total_count  (rsp.total_count),
        .fraction_q16 (rsp.fraction_q16),
        .empty_res    (rsp.empty_res)
    );

    // query item taken, and an all-zero result item
    logic query_take;
    logic rsp_zero;

    assign query_take = req.valid && req.ready && (req.func == FUNC_QUERY);
    assign rsp_zero   = (rsp.total_count == '0) && (rsp.inside_count == '0) &&
                        (rsp.fraction_q16 == '0);

    // a query occupies the block, so the request side closes right after it
    `RWRH_ASSERT_NEXT(a_query_closes_req, clk, rst_n, query_take, !req.ready)
    // an empty histogram reports all-zero counts and ratio
    `RWRH_ASSERT(a_empty_zero, clk, rst_n, rsp.valid && rsp.empty_res, rsp_zero)
    // the inside count never exceeds the total
    `RWRH_ASSERT(a_inside_le_total, clk, rst_n, rsp.valid, rsp.inside_count <= rsp.total_count)
    // the ratio never exceeds one
    `RWRH_ASSERT(a_frac_le_one, clk, rst_n, rsp.valid, rsp.fraction_q16 <= FRAC_ONE)

endmodule
